// ===== rtl/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the dirty rectangle tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

	localparam int DISPLAYS_DEF = 4;
	localparam int COORD_W      = 14;
	localparam int CFG_IDX_W    = 1;

	localparam logic [2:0] ACT_ADD       = 3'd0;
	localparam logic [2:0] ACT_CLOSE     = 3'd1;
	localparam logic [2:0] ACT_FULL_READ = 3'd2;
	localparam logic [2:0] ACT_MASK_READ = 3'd3;
	localparam logic [2:0] ACT_RESET     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 1'b1;

	typedef struct packed {
		logic [2:0]         action;
		logic [2:0]         display;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_w;
		logic signed [15:0] rect_h;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]         slot;
		logic               is_dirty;
		logic [COORD_W-1:0] box_x;
		logic [COORD_W-1:0] box_y;
		logic [COORD_W-1:0] box_w;
		logic [COORD_W-1:0] box_h;
		logic [7:0]         dirty_mask;
		logic               accepted;
		logic               last;
	} result_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
	} box_t;

	typedef struct packed {
		logic               keep;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
	} clip_t;

endpackage

// ===== rtl/drt_ram.sv =====
// ----------------------------------------------------------------------------
// drt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module drt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/drt_clip.sv =====
// ----------------------------------------------------------------------------
// drt_clip
// Clips an incoming rectangle to the screen and flags it when it stays
// non-empty.
// ----------------------------------------------------------------------------
module drt_clip (
	input  logic signed [15:0]          rect_x,
	input  logic signed [15:0]          rect_y,
	input  logic signed [15:0]          rect_w,
	input  logic signed [15:0]          rect_h,
	input  logic [drt_pkg::COORD_W-1:0] scr_width,
	input  logic [drt_pkg::COORD_W-1:0] scr_height,
	output drt_pkg::clip_t              clip
);

	logic signed [16:0] x1, y1, x2, y2;
	logic signed [16:0] cx1, cy1, cx2, cy2;
	logic signed [16:0] sw, sh;

	always_comb begin
		sw  = $signed({3'b000, scr_width});
		sh  = $signed({3'b000, scr_height});
		x1  = $signed({rect_x[15], rect_x});
		y1  = $signed({rect_y[15], rect_y});
		x2  = x1 + $signed({rect_w[15], rect_w});
		y2  = y1 + $signed({rect_h[15], rect_h});
		cx1 = (x1 < 17'sd0) ? 17'sd0 : x1;
		cy1 = (y1 < 17'sd0) ? 17'sd0 : y1;
		cx2 = (x2 > sw) ? sw : x2;
		cy2 = (y2 > sh) ? sh : y2;
		clip.keep = (scr_width != '0) && (scr_height != '0) && (cx1 < cx2) && (cy1 < cy2);
		clip.x1   = cx1[drt_pkg::COORD_W-1:0];
		clip.y1   = cy1[drt_pkg::COORD_W-1:0];
		clip.x2   = cx2[drt_pkg::COORD_W-1:0];
		clip.y2   = cy2[drt_pkg::COORD_W-1:0];
	end

endmodule

// ===== rtl/dirty_rect_tracker.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_tracker
// Keeps one damage rectangle per display, merging added rectangles into a
// bounding box, with close-write marking and full or mask reads that clear.
// ----------------------------------------------------------------------------
// Channel  Handshake     Payload
// cmd      start, busy   cmd    (drt_pkg::cmd_word_t)
// result   strobe        result (drt_pkg::result_word_t)
// config   cfg_we        cfg_index, cfg_data
//
// An add or close keeps busy high to clip against the box read from RAM at
// acceptance and then update, and its word appears on the cycle after.
// A full read keeps busy high while the box RAM is walked and gives one word per
// cycle, one entry per cycle.
// A mask read and a reset action do not raise busy; the word follows next cycle.
// After reset all slots are clean and the screen size is zero.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module dirty_rect_tracker #(
	parameter int DISPLAYS = drt_pkg::DISPLAYS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  drt_pkg::cmd_word_t               cmd,
	output logic                             strobe,
	output drt_pkg::result_word_t            result,
	input  logic                             cfg_we,
	input  logic [drt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [drt_pkg::COORD_W-1:0]      cfg_data
);

	localparam int DW = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;
	localparam int CW = drt_pkg::COORD_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CLIP = 4'b0010,
		S_UPD  = 4'b0100,
		S_WALK = 4'b1000
	} state_t;

	state_t                state_q;
	logic [DISPLAYS-1:0]   flag_q;
	logic [DISPLAYS-1:0]   whr_q;
	logic [DISPLAYS-1:0]   mask_q;
	logic [DW-1:0]         idx_q;
	logic [CW-1:0]         sw_q, sh_q;
	logic                  strobe_q;
	drt_pkg::result_word_t result_q;

	drt_pkg::cmd_word_t    cmd_s1;
	logic                  ok_s1;
	logic [DW-1:0]         di_s1;
	drt_pkg::clip_t        clip_s1;
	drt_pkg::box_t         box_s1;

	logic                  accept, ok_in;
	logic [DW-1:0]         di_in;
	logic [DW-1:0]         rd_addr;
	logic [$bits(drt_pkg::box_t)-1:0] rd_data;
	drt_pkg::box_t         rd_box;
	drt_pkg::clip_t        clip;

	logic                  is_add;
	logic                  upd_flag, upd_acc, upd_we, old_area;
	drt_pkg::box_t         upd_box, merge_box;
	logic [CW:0]           ox2, oy2, nx2, ny2;
	logic [CW-1:0]         nx1, ny1;
	logic                  walk_last;
	logic                  strobe_d;
	drt_pkg::result_word_t result_d;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;
	assign ok_in  = ({1'b0, cmd.display} < 4'(DISPLAYS));
	assign di_in  = cmd.display[DW-1:0];
	assign walk_last = (idx_q == DW'(DISPLAYS - 1));
	assign rd_box = rd_data;

	always_comb begin
		if (state_q == S_WALK) begin
			rd_addr = DW'(idx_q + 1'b1);
		end else if (cmd.action == drt_pkg::ACT_FULL_READ) begin
			rd_addr = '0;
		end else begin
			rd_addr = di_in;
		end
	end

	drt_ram #(
		.WIDTH ($bits(drt_pkg::box_t)),
		.DEPTH (DISPLAYS)
	) u_box_ram (
		.clk   (clk),
		.we    (upd_we),
		.waddr (di_s1),
		.wdata (upd_box),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	drt_clip u_clip (
		.rect_x     (cmd_s1.rect_x),
		.rect_y     (cmd_s1.rect_y),
		.rect_w     (cmd_s1.rect_w),
		.rect_h     (cmd_s1.rect_h),
		.scr_width  (sw_q),
		.scr_height (sh_q),
		.clip       (clip)
	);

	always_comb begin
		old_area = (box_s1.width != '0) && (box_s1.height != '0);
		ox2 = {1'b0, box_s1.left} + {1'b0, box_s1.width};
		oy2 = {1'b0, box_s1.top} + {1'b0, box_s1.height};
		if (old_area) begin
			nx1 = (clip_s1.x1 < box_s1.left) ? clip_s1.x1 : box_s1.left;
			ny1 = (clip_s1.y1 < box_s1.top) ? clip_s1.y1 : box_s1.top;
			nx2 = ({1'b0, clip_s1.x2} > ox2) ? {1'b0, clip_s1.x2} : ox2;
			ny2 = ({1'b0, clip_s1.y2} > oy2) ? {1'b0, clip_s1.y2} : oy2;
		end else begin
			nx1 = clip_s1.x1;
			ny1 = clip_s1.y1;
			nx2 = {1'b0, clip_s1.x2};
			ny2 = {1'b0, clip_s1.y2};
		end
		merge_box.left   = nx1;
		merge_box.top    = ny1;
		merge_box.width  = CW'(nx2 - {1'b0, nx1});
		merge_box.height = CW'(ny2 - {1'b0, ny1});

		is_add   = (cmd_s1.action == drt_pkg::ACT_ADD);
		upd_box  = box_s1;
		upd_flag = flag_q[di_s1];
		upd_acc  = 1'b0;
		upd_we   = 1'b0;
		if (state_q == S_UPD && ok_s1) begin
			if (is_add) begin
				if (clip_s1.keep) begin
					upd_box  = merge_box;
					upd_flag = 1'b1;
					upd_acc  = 1'b1;
					upd_we   = 1'b1;
				end
			end else begin
				if (!whr_q[di_s1]) begin
					if (old_area) begin
						upd_flag = 1'b1;
					end else if (sw_q != '0 && sh_q != '0) begin
						upd_flag       = 1'b1;
						upd_box.left   = '0;
						upd_box.top    = '0;
						upd_box.width  = sw_q;
						upd_box.height = sh_q;
						upd_we         = 1'b1;
					end
				end
				upd_acc = upd_flag;
			end
		end
	end

	always_comb begin
		strobe_d = 1'b0;
		result_d = result_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					result_d      = '0;
					result_d.last = 1'b1;
					if (cmd.action == drt_pkg::ACT_MASK_READ) begin
						result_d.dirty_mask = 8'(flag_q);
					end else begin
						result_d.slot = cmd.display;
					end
					strobe_d = (cmd.action == drt_pkg::ACT_MASK_READ) ||
						(cmd.action == drt_pkg::ACT_RESET);
				end
			end
			S_UPD: begin
				strobe_d          = 1'b1;
				result_d          = '0;
				result_d.slot     = cmd_s1.display;
				result_d.accepted = upd_acc;
				result_d.last     = 1'b1;
				if (ok_s1 && upd_flag) begin
					result_d.is_dirty = 1'b1;
					result_d.box_x    = upd_box.left;
					result_d.box_y    = upd_box.top;
					result_d.box_w    = upd_box.width;
					result_d.box_h    = upd_box.height;
				end
			end
			S_WALK: begin
				strobe_d            = 1'b1;
				result_d            = '0;
				result_d.slot       = 3'(idx_q);
				result_d.dirty_mask = 8'(mask_q);
				result_d.last       = walk_last;
				if (mask_q[idx_q]) begin
					result_d.is_dirty = 1'b1;
					result_d.box_x    = rd_box.left;
					result_d.box_y    = rd_box.top;
					result_d.box_w    = rd_box.width;
					result_d.box_h    = rd_box.height;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			flag_q   <= '0;
			whr_q    <= '0;
			mask_q   <= '0;
			idx_q    <= '0;
			sw_q     <= '0;
			sh_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
			if (cfg_we) begin
				unique case (cfg_index)
					drt_pkg::CFG_SCREEN_W: sw_q <= cfg_data;
					drt_pkg::CFG_SCREEN_H: sh_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.action) inside
							drt_pkg::ACT_ADD, drt_pkg::ACT_CLOSE: begin
								state_q <= S_CLIP;
							end
							drt_pkg::ACT_FULL_READ: begin
								mask_q  <= flag_q;
								flag_q  <= '0;
								idx_q   <= '0;
								state_q <= S_WALK;
							end
							drt_pkg::ACT_MASK_READ: begin
								flag_q <= '0;
							end
							drt_pkg::ACT_RESET: begin
								if (ok_in) begin
									flag_q[di_in] <= 1'b0;
									whr_q[di_in]  <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_CLIP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (ok_s1) begin
						flag_q[di_s1] <= upd_flag;
						if (is_add) begin
							if (clip_s1.keep) begin
								whr_q[di_s1] <= 1'b1;
							end
						end else begin
							whr_q[di_s1] <= 1'b0;
						end
					end
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if (walk_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= DW'(idx_q + 1'b1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_s1 <= cmd;
					ok_s1  <= ok_in;
					di_s1  <= di_in;
				end
			end
			S_CLIP: begin
				clip_s1 <= clip;
				box_s1  <= flag_q[di_s1] ? rd_box : '0;
			end
			default: ;
		endcase
	end

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.action == drt_pkg::ACT_FULL_READ ||
		cmd.action == drt_pkg::ACT_MASK_READ) |=> flag_q == '0)
		else $error("read did not clear the dirty flags");

	a_partial_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.last |-> state_q == S_WALK)
		else $error("non-final word outside a full read");

	a_dirty_has_area: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.is_dirty |-> result_q.box_w != '0 && result_q.box_h != '0)
		else $error("dirty word reported with an empty box");

endmodule
